/* rtl/core/cba_pkg.sv */
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator: command and
// result codes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package cba_pkg;

   // Sizing
   localparam int BLOCKS_DEF     = 64;   // default number of blocks in the map
   localparam int BLOCK_KB_SHIFT = 3;    // 8 KB blocks
   localparam int MAX_RESULTS    = 64;   // cap on listed runs per command
   localparam int OP_W           = 2;
   localparam int ID_W           = 16;
   localparam int SIZE_W         = 16;
   localparam int KIND_W         = 2;
   localparam int BIDX_W         = 6;    // reported block index width
   localparam int NEED_W         = SIZE_W - BLOCK_KB_SHIFT + 1;

   // Request operations
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_DEFRAG = 2'd3
   } op_type;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD = 2'd0,
      KIND_GET = 2'd1,
      KIND_RUN = 2'd2
   } kind_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_SCAN,
      ST_ADD_FILL,
      ST_GET_SCAN,
      ST_DEL_SCAN,
      ST_CMP_SCAN,
      ST_CMP_ZERO,
      ST_LIST_SCAN,
      ST_LIST_CLOSE,
      ST_LIST_FLUSH,
      ST_REPLY
   } state_type;

   // Datapath commands
   typedef enum logic [3:0] {
      DP_NONE,
      DP_CLEAR_STEP,
      DP_LOAD,
      DP_ADD_STEP,
      DP_FILL_STEP,
      DP_GET_STEP,
      DP_DEL_STEP,
      DP_CMP_STEP,
      DP_ZERO_STEP,
      DP_LIST_STEP,
      DP_LIST_CLOSE,
      DP_LIST_FLUSH,
      DP_REPLY
   } dp_cmd_type;

   // Datapath status towards the controller
   typedef struct packed {
      op_type op;
      logic   idx_last;
      logic   add_bad;
      logic   add_fit;
      logic   fill_last;
      logic   dst_end;
      logic   list_full;
      logic   list_stall;
      logic   run_open;
      logic   close_stall;
      logic   out_free;
   } dp_status_type;

endpackage

/* rtl/core/cba_req_if.sv */
// ----------------------------------------------------------------------------
// cba_req_if
// Request channel: valid/ready handshake carrying one allocator command.
// ----------------------------------------------------------------------------
interface cba_req_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::OP_W-1:0]      operation;
   logic [cba_pkg::ID_W-1:0]      file_id;
   logic [cba_pkg::SIZE_W-1:0]    size_kb;

   modport source (output valid, output operation, output file_id, output size_kb,
                   input ready);
   modport sink   (input valid, input operation, input file_id, input size_kb,
                   output ready);
endinterface

/* rtl/core/cba_rsp_if.sv */
// ----------------------------------------------------------------------------
// cba_rsp_if
// Response channel: valid/ready handshake carrying one allocator result.
// ----------------------------------------------------------------------------
interface cba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cba_pkg::KIND_W-1:0]    kind;
   logic                          ok;
   logic [cba_pkg::ID_W-1:0]      run_id;
   logic [cba_pkg::BIDX_W-1:0]    first_block;
   logic [cba_pkg::BIDX_W-1:0]    last_block;
   logic                          last;

   modport source (output valid, output kind, output ok, output run_id,
                   output first_block, output last_block, output last,
                   input ready);
   modport sink   (input valid, input kind, input ok, input run_id,
                   input first_block, input last_block, input last,
                   output ready);
endinterface

/* rtl/core/contiguous_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core
// First-fit allocator of contiguous 8 KB blocks with compaction and run
// listing, built as a controller state machine and a map datapath.
// ----------------------------------------------------------------------------
// The block map lives in a single-port-write memory that is read one entry a
// cycle; get, delete and defragment scan all BLOCKS entries, an add scan stops
// at the first fit. After reset a clearing pass over all BLOCKS entries runs
// before the first request is taken. Add scans for a free run, then claims its
// blocks one by one, and is refused without a scan when the size or id is bad;
// get makes one scan pass. Delete makes a free pass, then a listing pass;
// defragment makes a pack pass, a clearing of the vacated top and a listing
// pass. Each listed run is one transaction on the response channel, the final
// one flagged last; a stalled response channel holds the listing pass and the
// final answer. Requests are taken one at a time, and a new one may be
// accepted while the previous final response still waits in the output
// register.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core #(
   parameter int BLOCKS = cba_pkg::BLOCKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cba_req_if.sink    req_chan,
   cba_rsp_if.source  rsp_chan
);

   cba_pkg::dp_cmd_type    cmd;
   cba_pkg::dp_status_type status;

   // Sequencing
   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Map, scan logic and response register
   cba_datapath #(
      .BLOCKS (BLOCKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_chan.operation),
      .req_file_id     (req_chan.file_id),
      .req_size_kb     (req_chan.size_kb),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kind        (rsp_chan.kind),
      .rsp_ok          (rsp_chan.ok),
      .rsp_run_id      (rsp_chan.run_id),
      .rsp_first_block (rsp_chan.first_block),
      .rsp_last_block  (rsp_chan.last_block),
      .rsp_last        (rsp_chan.last)
   );

endmodule

/* rtl/core/cba_ctrl.sv */
// ----------------------------------------------------------------------------
// cba_ctrl
// Allocator controller: sequences the clearing pass, the per-command scans
// over the block map and the result hand-off, issuing datapath commands.
// ----------------------------------------------------------------------------
module cba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cba_pkg::dp_status_type status,
   output cba_pkg::dp_cmd_type    cmd
);

   cba_pkg::state_type state_ff;
   cba_pkg::state_type state_in;

   // State register; start with the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cba_pkg::ST_CLEAR: begin
            if (status.idx_last) state_in = cba_pkg::ST_IDLE;
         end
         cba_pkg::ST_IDLE: begin
            if (req_valid) state_in = cba_pkg::ST_DISPATCH;
         end
         cba_pkg::ST_DISPATCH: begin
            unique case (status.op)
               cba_pkg::OP_ADD: begin
                  state_in = status.add_bad ? cba_pkg::ST_REPLY : cba_pkg::ST_ADD_SCAN;
               end
               cba_pkg::OP_GET:    state_in = cba_pkg::ST_GET_SCAN;
               cba_pkg::OP_DELETE: state_in = cba_pkg::ST_DEL_SCAN;
               cba_pkg::OP_DEFRAG: state_in = cba_pkg::ST_CMP_SCAN;
               default:            state_in = cba_pkg::ST_IDLE;
            endcase
         end
         cba_pkg::ST_ADD_SCAN: begin
            if (status.add_fit) begin
               state_in = cba_pkg::ST_ADD_FILL;
            end else if (status.idx_last) begin
               state_in = cba_pkg::ST_REPLY;
            end
         end
         cba_pkg::ST_ADD_FILL: begin
            if (status.fill_last) state_in = cba_pkg::ST_REPLY;
         end
         cba_pkg::ST_GET_SCAN: begin
            if (status.idx_last) state_in = cba_pkg::ST_REPLY;
         end
         cba_pkg::ST_DEL_SCAN: begin
            if (status.idx_last) state_in = cba_pkg::ST_LIST_SCAN;
         end
         cba_pkg::ST_CMP_SCAN: begin
            if (status.idx_last) state_in = cba_pkg::ST_CMP_ZERO;
         end
         cba_pkg::ST_CMP_ZERO: begin
            if (status.dst_end) state_in = cba_pkg::ST_LIST_SCAN;
         end
         cba_pkg::ST_LIST_SCAN: begin
            if (status.list_full) begin
               state_in = cba_pkg::ST_LIST_CLOSE;
            end else if (!status.list_stall && status.idx_last) begin
               state_in = cba_pkg::ST_LIST_CLOSE;
            end
         end
         cba_pkg::ST_LIST_CLOSE: begin
            if (!status.run_open || !status.close_stall) state_in = cba_pkg::ST_LIST_FLUSH;
         end
         cba_pkg::ST_LIST_FLUSH: begin
            if (status.out_free) state_in = cba_pkg::ST_IDLE;
         end
         cba_pkg::ST_REPLY: begin
            if (status.out_free) state_in = cba_pkg::ST_IDLE;
         end
         default: state_in = cba_pkg::ST_IDLE;
      endcase
   end

   // Outputs: datapath command and request ready
   always_comb begin
      cmd       = cba_pkg::DP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         cba_pkg::ST_CLEAR:    cmd = cba_pkg::DP_CLEAR_STEP;
         cba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = cba_pkg::DP_LOAD;
         end
         cba_pkg::ST_DISPATCH: cmd = cba_pkg::DP_NONE;
         cba_pkg::ST_ADD_SCAN: cmd = cba_pkg::DP_ADD_STEP;
         cba_pkg::ST_ADD_FILL: cmd = cba_pkg::DP_FILL_STEP;
         cba_pkg::ST_GET_SCAN: cmd = cba_pkg::DP_GET_STEP;
         cba_pkg::ST_DEL_SCAN: cmd = cba_pkg::DP_DEL_STEP;
         cba_pkg::ST_CMP_SCAN: cmd = cba_pkg::DP_CMP_STEP;
         cba_pkg::ST_CMP_ZERO: begin
            if (!status.dst_end) cmd = cba_pkg::DP_ZERO_STEP;
         end
         cba_pkg::ST_LIST_SCAN: begin
            if (!status.list_full && !status.list_stall) cmd = cba_pkg::DP_LIST_STEP;
         end
         cba_pkg::ST_LIST_CLOSE: begin
            if (status.run_open && !status.close_stall) cmd = cba_pkg::DP_LIST_CLOSE;
         end
         cba_pkg::ST_LIST_FLUSH: begin
            if (status.out_free) cmd = cba_pkg::DP_LIST_FLUSH;
         end
         cba_pkg::ST_REPLY: begin
            if (status.out_free) cmd = cba_pkg::DP_REPLY;
         end
         default: cmd = cba_pkg::DP_NONE;
      endcase
   end

endmodule

/* rtl/core/cba_datapath.sv */
// ----------------------------------------------------------------------------
// cba_datapath
// Allocator datapath: block map memory, scan index and pointers, run
// tracking, a one-deep pending run buffer and the response output register.
// ----------------------------------------------------------------------------
module cba_datapath #(
   parameter int BLOCKS = cba_pkg::BLOCKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cba_pkg::dp_cmd_type           cmd,
   output cba_pkg::dp_status_type        status,
   input  logic [cba_pkg::OP_W-1:0]      req_operation,
   input  logic [cba_pkg::ID_W-1:0]      req_file_id,
   input  logic [cba_pkg::SIZE_W-1:0]    req_size_kb,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cba_pkg::KIND_W-1:0]    rsp_kind,
   output logic                          rsp_ok,
   output logic [cba_pkg::ID_W-1:0]      rsp_run_id,
   output logic [cba_pkg::BIDX_W-1:0]    rsp_first_block,
   output logic [cba_pkg::BIDX_W-1:0]    rsp_last_block,
   output logic                          rsp_last
);

   localparam int AW  = $clog2(BLOCKS);
   localparam int CW  = $clog2(BLOCKS + 1);
   localparam int NCW = $clog2(cba_pkg::MAX_RESULTS + 1);
   localparam int IW  = cba_pkg::ID_W;
   localparam int NW  = cba_pkg::NEED_W;
   localparam int BW  = cba_pkg::BIDX_W;

   // Block map memory
   logic [IW-1:0] map_mem [BLOCKS];
   logic [IW-1:0] mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [IW-1:0] mem_wdata;

   // Command context
   cba_pkg::op_type op_ff, op_in;
   logic [IW-1:0]   id_ff, id_in;
   logic [NW-1:0]   need_ff, need_in;
   logic            add_bad_ff, add_bad_in;

   // Scan pointers and counters
   logic [AW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   dst_ff, dst_in;
   logic [CW-1:0]   run_ff, run_in;
   logic [NCW-1:0]  n_ff, n_in;

   // Found range
   logic            found_ff, found_in;
   logic [AW-1:0]   first_ff, first_in;
   logic [AW-1:0]   lastb_ff, lastb_in;

   // Open run and pending run
   logic [IW-1:0]   cur_id_ff, cur_id_in;
   logic [AW-1:0]   cur_start_ff, cur_start_in;
   logic            pend_valid_ff, pend_valid_in;
   logic [IW-1:0]   pend_id_ff, pend_id_in;
   logic [AW-1:0]   pend_first_ff, pend_first_in;
   logic [AW-1:0]   pend_lastb_ff, pend_lastb_in;

   // Output register
   logic              out_valid_ff, out_valid_in;
   cba_pkg::kind_type out_kind_ff, out_kind_in;
   logic              out_ok_ff, out_ok_in;
   logic [IW-1:0]     out_id_ff, out_id_in;
   logic [BW-1:0]     out_first_ff, out_first_in;
   logic [BW-1:0]     out_lastb_ff, out_lastb_in;
   logic              out_last_ff, out_last_in;

   // Derived values
   logic [NW-1:0]   req_need;
   logic            idx_last;
   logic [AW-1:0]   idx_next;
   logic            free;
   logic [CW-1:0]   run_inc;
   logic            add_fit;
   logic [AW-1:0]   fit_start;
   logic            id_hit;
   logic            run_ends;
   logic            out_free;

   // Push into the output register
   logic              push_en;
   cba_pkg::kind_type push_kind;
   logic              push_ok;
   logic [IW-1:0]     push_id;
   logic [AW-1:0]     push_first;
   logic [AW-1:0]     push_lastb;
   logic              push_last;

   // Round the size up to whole blocks
   assign req_need = NW'(req_size_kb >> cba_pkg::BLOCK_KB_SHIFT)
                   + NW'(|req_size_kb[cba_pkg::BLOCK_KB_SHIFT-1:0]);

   assign idx_last  = (idx_ff == AW'(BLOCKS - 1));
   assign idx_next  = idx_last ? '0 : idx_ff + AW'(1);
   assign free      = (mem_q_ff == '0);
   assign run_inc   = run_ff + CW'(1);
   assign add_fit   = free && (NW'(run_inc) == need_ff);
   assign fit_start = AW'(CW'(idx_ff) + CW'(1) - CW'(need_ff));
   assign id_hit    = (id_ff != '0) && (mem_q_ff == id_ff);
   assign run_ends  = (cur_id_ff != '0) && (mem_q_ff != cur_id_ff);
   assign out_free  = !out_valid_ff || rsp_ready;

   // Status towards the controller
   always_comb begin
      status.op          = op_ff;
      status.idx_last    = idx_last;
      status.add_bad     = add_bad_ff;
      status.add_fit     = add_fit;
      status.fill_last   = (dst_ff[AW-1:0] == lastb_ff);
      status.dst_end     = (dst_ff == CW'(BLOCKS));
      status.list_full   = (n_ff == NCW'(cba_pkg::MAX_RESULTS));
      status.list_stall  = run_ends && pend_valid_ff && !out_free;
      status.run_open    = (cur_id_ff != '0) && (n_ff < NCW'(cba_pkg::MAX_RESULTS));
      status.close_stall = pend_valid_ff && !out_free;
      status.out_free    = out_free;
   end

   // Command decode
   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      need_in       = need_ff;
      add_bad_in    = add_bad_ff;
      idx_in        = idx_ff;
      dst_in        = dst_ff;
      run_in        = run_ff;
      n_in          = n_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      lastb_in      = lastb_ff;
      cur_id_in     = cur_id_ff;
      cur_start_in  = cur_start_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_first_in = pend_first_ff;
      pend_lastb_in = pend_lastb_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = '0;
      push_en       = 1'b0;
      push_kind     = cba_pkg::KIND_RUN;
      push_ok       = 1'b1;
      push_id       = pend_id_ff;
      push_first    = pend_first_ff;
      push_lastb    = pend_lastb_ff;
      push_last     = 1'b0;

      unique case (cmd)
         cba_pkg::DP_NONE: begin
         end
         cba_pkg::DP_CLEAR_STEP: begin
            mem_we = 1'b1;
            idx_in = idx_next;
         end
         cba_pkg::DP_LOAD: begin
            op_in         = cba_pkg::op_type'(req_operation);
            id_in         = req_file_id;
            need_in       = req_need;
            add_bad_in    = (req_file_id == '0) || (req_need == '0)
                          || (req_need > NW'(BLOCKS));
            idx_in        = '0;
            dst_in        = '0;
            run_in        = '0;
            n_in          = '0;
            found_in      = 1'b0;
            first_in      = '0;
            lastb_in      = '0;
            cur_id_in     = '0;
            cur_start_in  = '0;
            pend_valid_in = 1'b0;
         end
         cba_pkg::DP_ADD_STEP: begin
            // Count free blocks in a row; the first run reaching need wins
            idx_in = idx_next;
            run_in = free ? run_inc : '0;
            if (add_fit) begin
               found_in = 1'b1;
               first_in = fit_start;
               lastb_in = idx_ff;
               dst_in   = CW'(fit_start);
            end
         end
         cba_pkg::DP_FILL_STEP: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff[AW-1:0];
            mem_wdata = id_ff;
            dst_in    = dst_ff + CW'(1);
         end
         cba_pkg::DP_GET_STEP: begin
            idx_in = idx_next;
            if (id_hit) begin
               if (!found_ff) first_in = idx_ff;
               found_in = 1'b1;
               lastb_in = idx_ff;
            end
         end
         cba_pkg::DP_DEL_STEP: begin
            idx_in = idx_next;
            mem_we = id_hit;
         end
         cba_pkg::DP_CMP_STEP: begin
            // Move each used block down to the destination pointer
            idx_in = idx_next;
            if (!free) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff[AW-1:0];
               mem_wdata = mem_q_ff;
               dst_in    = dst_ff + CW'(1);
            end
         end
         cba_pkg::DP_ZERO_STEP: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff[AW-1:0];
            dst_in    = dst_ff + CW'(1);
         end
         cba_pkg::DP_LIST_STEP: begin
            // Close the open run into the pending slot, releasing the old one
            idx_in = idx_next;
            if (run_ends) begin
               push_en       = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_id_in    = cur_id_ff;
               pend_first_in = cur_start_ff;
               pend_lastb_in = idx_ff - AW'(1);
               n_in          = n_ff + NCW'(1);
            end
            if (mem_q_ff != cur_id_ff) begin
               cur_id_in    = mem_q_ff;
               cur_start_in = idx_ff;
            end
         end
         cba_pkg::DP_LIST_CLOSE: begin
            // Run still open at the top of the map
            push_en       = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_id_in    = cur_id_ff;
            pend_first_in = cur_start_ff;
            pend_lastb_in = AW'(BLOCKS - 1);
            n_in          = n_ff + NCW'(1);
            cur_id_in     = '0;
         end
         cba_pkg::DP_LIST_FLUSH: begin
            push_en       = 1'b1;
            push_last     = 1'b1;
            pend_valid_in = 1'b0;
            if (!pend_valid_ff) begin
               push_ok    = 1'b0;
               push_id    = '0;
               push_first = '0;
               push_lastb = '0;
            end
         end
         cba_pkg::DP_REPLY: begin
            push_en    = 1'b1;
            push_kind  = (op_ff == cba_pkg::OP_ADD) ? cba_pkg::KIND_ADD : cba_pkg::KIND_GET;
            push_ok    = found_ff;
            push_id    = id_ff;
            push_first = found_ff ? first_ff : '0;
            push_lastb = found_ff ? lastb_ff : '0;
            push_last  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Output register: load on push, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_ok_in    = out_ok_ff;
      out_id_in    = out_id_ff;
      out_first_in = out_first_ff;
      out_lastb_in = out_lastb_ff;
      out_last_in  = out_last_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (push_en) begin
         out_valid_in = 1'b1;
         out_kind_in  = push_kind;
         out_ok_in    = push_ok;
         out_id_in    = push_id;
         out_first_in = BW'(push_first);
         out_lastb_in = BW'(push_lastb);
         out_last_in  = push_last;
      end
   end

   // Map memory: one write port, registered read at the next scan index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= map_mem[idx_in];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      need_ff       <= need_in;
      add_bad_ff    <= add_bad_in;
      dst_ff        <= dst_in;
      run_ff        <= run_in;
      n_ff          <= n_in;
      found_ff      <= found_in;
      first_ff      <= first_in;
      lastb_ff      <= lastb_in;
      cur_id_ff     <= cur_id_in;
      cur_start_ff  <= cur_start_in;
      pend_id_ff    <= pend_id_in;
      pend_first_ff <= pend_first_in;
      pend_lastb_ff <= pend_lastb_in;
      out_kind_ff   <= out_kind_in;
      out_ok_ff     <= out_ok_in;
      out_id_ff     <= out_id_in;
      out_first_ff  <= out_first_in;
      out_lastb_ff  <= out_lastb_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_ok          = out_ok_ff;
   assign rsp_run_id      = out_id_ff;
   assign rsp_first_block = out_first_ff;
   assign rsp_last_block  = out_lastb_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contiguous block allocator core. A clocked
// driver feeds allocator commands from a queue filled up front, a clocked
// monitor predicts the answers and run listings of every accepted command
// from its own copy of the block map and checks each response in order.
// ----------------------------------------------------------------------------
module tb;
   import cba_pkg::*;

   localparam int NBLK           = BLOCKS_DEF;
   localparam int BLOCK_KB       = 1 << BLOCK_KB_SHIFT;
   localparam int CMD_TARGET     = 425;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4 * NBLK;

   typedef struct {
      op_type      op;
      logic [15:0] file_id;
      logic [15:0] size_kb;
      logic        drain;     // hold this command until every answer is back
   } command_type;

   typedef struct {
      kind_type    kind;
      logic        ok;
      logic [15:0] run_id;
      logic [5:0]  first_block;
      logic [5:0]  last_block;
      logic        last;
   } answer_type;

   // Clock, reset and driven inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              drv_valid     = 1'b0;
   logic [OP_W-1:0]   drv_op        = '0;
   logic [ID_W-1:0]   drv_id        = '0;
   logic [SIZE_W-1:0] drv_size      = '0;
   logic              drv_rsp_ready = 1'b0;

   cba_req_if req_if ();
   cba_rsp_if rsp_if ();

   assign req_if.valid     = drv_valid;
   assign req_if.operation = drv_op;
   assign req_if.file_id   = drv_id;
   assign req_if.size_kb   = drv_size;
   assign rsp_if.ready     = drv_rsp_ready;

   contiguous_block_allocator_core #(.BLOCKS(NBLK)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial forever #1 clock = ~clock;

   // Stimulus and prediction state
   command_type pending_cmds[$];
   command_type cur_cmd = '{op: OP_GET, file_id: '0, size_kb: '0, drain: 1'b0};
   answer_type  expected_answers[$];
   logic [15:0] block_map [NBLK] = '{default: '0};
   logic [15:0] id_pool [6] = '{16'h0001, 16'h0002, 16'h00A5, 16'h1234, 16'h8000, 16'hFFFF};
   bit          id_seen [65536];
   logic [15:0] added_ids[$];
   bit          drain_next = 1'b0;
   bit          req_showing = 1'b0;
   bit          req_fired = 1'b0;
   bit          rsp_fired = 1'b0;
   int          n_total = 1;
   int          n_accepted = 0;
   int          n_checked = 0;
   int          n_errors = 0;
   int          idle_cycles = 0;
   int          n_add_ok = 0;
   int          n_add_refused = 0;
   int          n_get_found = 0;
   int          longest_listing = 0;

   // Report one failure on one line and count it
   task automatic flag_error(string msg);
      $display("tb: mismatch: %s", msg);
      n_errors++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("response %0d: %s is %0h, expected %0h",
                              n_checked, name, got, want));
   endtask

   function automatic void expect_answer(kind_type kind, logic ok, logic [15:0] id,
                                         int first, int lastb, logic last);
      answer_type a;
      a.kind        = kind;
      a.ok          = ok;
      a.run_id      = id;
      a.first_block = 6'(first);
      a.last_block  = 6'(lastb);
      a.last        = last;
      expected_answers.push_back(a);
   endfunction

   // List each maximal run of one nonzero id, lowest first, up to MAX_RESULTS runs
   function automatic void expect_run_listing();
      int          n;
      int          idx;
      int          start;
      logic [15:0] rid;
      n   = 0;
      idx = 0;
      while (idx < NBLK && n < MAX_RESULTS) begin
         if (block_map[idx] == 16'h0000) begin
            idx++;
         end else begin
            rid   = block_map[idx];
            start = idx;
            while (idx < NBLK && block_map[idx] == rid)
               idx++;
            expect_answer(KIND_RUN, 1'b1, rid, start, idx - 1, 1'b0);
            n++;
         end
      end
      if (n == 0)
         expect_answer(KIND_RUN, 1'b0, 16'h0000, 0, 0, 1'b1);
      else
         expected_answers[expected_answers.size() - 1].last = 1'b1;
      if (n > longest_listing)
         longest_listing = n;
   endfunction

   // Apply one accepted command to the shadow map and queue its answers
   function automatic void predict_command(command_type c);
      int need;
      int start;
      int j;
      int fb;
      int lb;
      int dst;
      bit fits;
      bit found;
      case (c.op)
         OP_ADD: begin
            need = int'(c.size_kb) / BLOCK_KB + ((int'(c.size_kb) % BLOCK_KB) != 0);
            fb   = -1;
            if (c.file_id != 16'h0000 && need != 0 && need <= NBLK) begin
               for (start = 0; start + need <= NBLK && fb < 0; start++) begin
                  fits = 1'b1;
                  for (j = 0; j < need; j++)
                     if (block_map[start + j] != 16'h0000)
                        fits = 1'b0;
                  if (fits)
                     fb = start;
               end
            end
            if (fb >= 0) begin
               for (j = 0; j < need; j++)
                  block_map[fb + j] = c.file_id;
               expect_answer(KIND_ADD, 1'b1, c.file_id, fb, fb + need - 1, 1'b1);
               n_add_ok++;
            end else begin
               expect_answer(KIND_ADD, 1'b0, c.file_id, 0, 0, 1'b1);
               n_add_refused++;
            end
         end
         OP_GET: begin
            found = 1'b0;
            fb    = 0;
            lb    = 0;
            if (c.file_id != 16'h0000) begin
               for (j = 0; j < NBLK; j++) begin
                  if (block_map[j] == c.file_id) begin
                     if (!found)
                        fb = j;
                     found = 1'b1;
                     lb    = j;
                  end
               end
            end
            if (found)
               n_get_found++;
            expect_answer(KIND_GET, found, c.file_id, fb, lb, 1'b1);
         end
         OP_DELETE: begin
            if (c.file_id != 16'h0000)
               for (j = 0; j < NBLK; j++)
                  if (block_map[j] == c.file_id)
                     block_map[j] = 16'h0000;
            expect_run_listing();
         end
         default: begin
            dst = 0;
            for (j = 0; j < NBLK; j++) begin
               if (block_map[j] != 16'h0000) begin
                  block_map[dst] = block_map[j];
                  if (dst != j)
                     block_map[j] = 16'h0000;
                  dst++;
               end
            end
            expect_run_listing();
         end
      endcase
   endfunction

   // Queue a command; remember added ids so the map can be wiped later
   function automatic void push_cmd(op_type op, logic [15:0] id, logic [15:0] size);
      command_type c;
      c.op       = op;
      c.file_id  = id;
      c.size_kb  = size;
      c.drain    = drain_next;
      drain_next = 1'b0;
      pending_cmds.push_back(c);
      if (op == OP_ADD && !id_seen[id]) begin
         id_seen[id] = 1'b1;
         added_ids.push_back(id);
      end
   endfunction

   function automatic logic [15:0] pick_id();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 80)
         return id_pool[$urandom_range(0, 5)];
      else if (sel < 88)
         return 16'h0000;
      else
         return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_size();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)
         return 16'($urandom_range(1, 128));
      else if (sel < 75)
         return 16'($urandom_range(1, 24));
      else if (sel < 82)
         return 16'($urandom_range(0, 3) * BLOCK_KB);
      else if (sel < 92)
         return 16'($urandom);
      else
         return 16'($urandom_range(500, 520));
   endfunction

   // Free every id added so far, lay down alternating single blocks, then defragment, get one id and delete the other
   function automatic void push_run_burst();
      int          i;
      logic [15:0] id_a;
      logic [15:0] id_b;
      foreach (added_ids[k])
         push_cmd(OP_DELETE, added_ids[k], 16'h0000);
      foreach (added_ids[k])
         id_seen[added_ids[k]] = 1'b0;
      added_ids.delete();
      i    = $urandom_range(0, 5);
      id_a = id_pool[i];
      id_b = id_pool[(i + 1 + $urandom_range(0, 4)) % 6];
      for (int k = 0; k < NBLK; k++)
         push_cmd(OP_ADD, (k % 2) ? id_b : id_a, 16'($urandom_range(1, BLOCK_KB)));
      push_cmd(OP_DEFRAG, 16'($urandom), 16'($urandom));
      push_cmd(OP_GET, id_a, 16'h0000);
      push_cmd(OP_DELETE, id_b, 16'h0000);
   endfunction

   // Driver: present commands and receiver readiness at the falling edge
   always @(negedge clock) begin
      int phase;
      int sender_idle;
      int receiver_idle;
      phase         = (n_accepted * 3) / n_total;
      sender_idle   = (phase == 0) ? 28 : (phase == 1) ? 71 : 0;
      receiver_idle = (phase == 0) ? 71 : (phase == 1) ? 28 : 0;
      if (!reset) begin
         // drop the command that went through at the last rising edge
         if (req_showing && req_fired)
            req_showing = 1'b0;
         if (!req_showing && pending_cmds.size() != 0 &&
             !(pending_cmds[0].drain && expected_answers.size() != 0) &&
             $urandom_range(0, 99) >= sender_idle) begin
            cur_cmd     = pending_cmds.pop_front();
            req_showing = 1'b1;
         end
      end
      drv_valid     <= req_showing;
      drv_op        <= cur_cmd.op;
      drv_id        <= cur_cmd.file_id;
      drv_size      <= cur_cmd.size_kb;
      drv_rsp_ready <= ($urandom_range(0, 99) >= receiver_idle);
   end

   // Monitor: sample both channels at the rising edge, check, then predict
   always @(posedge clock) begin
      answer_type want;
      req_fired = !reset && drv_valid && req_if.ready;
      rsp_fired = !reset && rsp_if.valid && drv_rsp_ready;
      if (rsp_fired) begin
         if (expected_answers.size() == 0) begin
            flag_error($sformatf("unexpected response kind %0d id %0h",
                                 rsp_if.kind, rsp_if.run_id));
         end else begin
            want = expected_answers.pop_front();
            compare_field("kind", rsp_if.kind, want.kind);
            compare_field("ok", rsp_if.ok, want.ok);
            compare_field("run_id", rsp_if.run_id, want.run_id);
            compare_field("first_block", rsp_if.first_block, want.first_block);
            compare_field("last_block", rsp_if.last_block, want.last_block);
            compare_field("last", rsp_if.last, want.last);
            n_checked++;
         end
      end
      if (req_fired) begin
         predict_command(cur_cmd);
         n_accepted++;
      end
      idle_cycles = (req_fired || rsp_fired) ? 0 : idle_cycles + 1;
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("tb: watchdog expired, %0d answers outstanding", expected_answers.size());
      $display("tb: done, errors");
      $finish;
   end

   // Build the command list, run reset, wait for the traffic to finish
   initial begin
      int bursts;
      int sel;
      bit drained;

      // Empty map corners
      push_cmd(OP_GET, 16'h0000, 16'h0000);
      push_cmd(OP_DEFRAG, 16'h0000, 16'h0000);
      push_cmd(OP_DELETE, 16'h0000, 16'hFFFF);
      // Refused adds: zero size, zero id
      push_cmd(OP_ADD, 16'h0005, 16'h0000);
      push_cmd(OP_ADD, 16'h0000, 16'h0008);
      // Whole map in one file, then full-map refusal
      push_cmd(OP_ADD, 16'h8000, 16'(NBLK * BLOCK_KB));
      push_cmd(OP_GET, 16'h8000, 16'h0000);
      push_cmd(OP_ADD, 16'h0001, 16'h0001);
      push_cmd(OP_DELETE, 16'h8000, 16'h0000);
      // Rounding up, oversize requests
      push_cmd(OP_ADD, 16'hFFFF, 16'h0001);
      push_cmd(OP_ADD, 16'h0001, 16'h0008);
      push_cmd(OP_ADD, 16'h0002, 16'h0009);
      push_cmd(OP_ADD, 16'h0003, 16'hFFFF);
      push_cmd(OP_ADD, 16'h0004, 16'(NBLK * BLOCK_KB + 1));
      push_cmd(OP_GET, 16'hFFFF, 16'h0000);
      push_cmd(OP_GET, 16'h0007, 16'h0000);
      // Hole too small for the next add, then compaction
      drain_next = 1'b1;
      push_cmd(OP_DELETE, 16'h0001, 16'h0000);
      push_cmd(OP_ADD, 16'h0005, 16'h0010);
      push_cmd(OP_DEFRAG, 16'h0000, 16'h0000);
      // Fill the rest exactly, then no free run left
      push_cmd(OP_ADD, 16'h5555, 16'((NBLK - 5) * BLOCK_KB));
      push_cmd(OP_ADD, 16'h0009, 16'h0007);
      push_cmd(OP_GET, 16'h0002, 16'h0000);
      push_cmd(OP_DELETE, 16'hFFFF, 16'h0000);
      push_cmd(OP_DEFRAG, 16'hAAAA, 16'h5555);
      push_cmd(OP_DELETE, 16'h7777, 16'h0000);

      // Random traffic, mostly valid commands on a small id pool
      bursts  = 0;
      drained = 1'b0;
      while (pending_cmds.size() < CMD_TARGET) begin
         if (bursts < 2 && pending_cmds.size() >= 150 * (bursts + 1)) begin
            push_run_burst();
            bursts++;
         end
         if (!drained && pending_cmds.size() >= 230) begin
            drain_next = 1'b1;
            drained    = 1'b1;
         end
         sel = $urandom_range(0, 99);
         if (sel < 45)
            push_cmd(OP_ADD, pick_id(), pick_size());
         else if (sel < 65)
            push_cmd(OP_GET, pick_id(), 16'($urandom));
         else if (sel < 83)
            push_cmd(OP_DELETE, pick_id(), 16'($urandom));
         else if (sel < 95)
            push_cmd(OP_DEFRAG, 16'($urandom), 16'($urandom));
         else
            push_cmd(op_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end
      n_total = pending_cmds.size();

      // Hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_showing)
         @(posedge clock);
      while (expected_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_answers.size() != 0)
         flag_error($sformatf("%0d answers never arrived", expected_answers.size()));

      $display("tb: %0d commands, %0d responses checked; adds placed %0d, refused %0d",
               n_accepted, n_checked, n_add_ok, n_add_refused);
      $display("tb: gets found %0d, longest run listing %0d entries, %0d errors",
               n_get_found, longest_listing, n_errors);
      if (n_errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/cba_pkg.sv
rtl/core/cba_req_if.sv
rtl/core/cba_rsp_if.sv
rtl/core/cba_ctrl.sv
rtl/core/cba_datapath.sv
rtl/core/contiguous_block_allocator_core.sv
verif/tb.sv
